// File: design/gdsw_pkg.sv
// Shared widths, constants and calendar lookup functions for the Gregorian
// date step and weekday core. No dependencies.
package gdsw_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 3;

    typedef logic [YEAR_W-1:0]  year_t;
    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [DAY_W-1:0]   day_t;
    typedef logic [WDAY_W-1:0]  wday_t;

    localparam year_t  YEAR_MAX  = 14'd9999;
    localparam month_t MONTH_JAN = 4'd1;
    localparam month_t MONTH_DEC = 4'd12;
    localparam day_t   DOM_FIRST = 5'd1;
    localparam wday_t  WDAY_SUN  = 3'd7;

    // floor(x / 100) = (x * 5243) >> 19 for x below 43699
    localparam int          DIV100_SH  = 19;
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam int          PROD100_W  = 27;

    // floor(x / 7) = (x * 37450) >> 18 for x below 43690
    localparam int          DIV7_SH  = 18;
    localparam logic [15:0] DIV7_MUL = 16'd37450;
    localparam int          PROD7_W  = 31;

    // Day count modulo 7 width (sum of year and day-of-year terms)
    localparam int CNT_W = 15;

    // Length of a month, 0 for a month number that does not exist
    function automatic day_t month_len(input month_t m, input logic leap);
        day_t len;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in the year before the first of month m
    function automatic logic [8:0] days_before(input month_t m, input logic leap);
        logic [8:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        if (leap && (m > 4'd2))
        begin
            n = n + 9'd1;
        end
        return n;
    endfunction

endpackage

// File: design/gregorian_date_step_and_weekday_core.sv
// Gregorian date step and weekday core: validity, following day, weekday and
// next Monday of one date per cycle. Depends on gdsw_pkg.
//
//  channel | ports                                   | marker
//  --------+-----------------------------------------+------------------------
//  in      | in_year, in_month, in_day               | start && !busy
//  out     | date_valid, next_year, next_month,       | done, one cycle
//          | next_dom, weekday, monday_year,          |
//          | monday_month, monday_dom, year_overflow  |
//
// One word enters per cycle; each result passes the input register, stages 2 to 4
// and the output registers. The stages are set by the two constant multiplies
// (divide by 100, then divide by 7 on the day count), each with a register after it.
// Reset clears the stage valid bits; busy is high only in the cycle after reset.
// Nothing stalls: done is a one-cycle strobe the receiver must take.
module gregorian_date_step_and_weekday_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [gdsw_pkg::YEAR_W-1:0]         in_year,
    input  logic [gdsw_pkg::MONTH_W-1:0]        in_month,
    input  logic [gdsw_pkg::DAY_W-1:0]          in_day,
    output logic                                done,
    output logic                                date_valid,
    output logic [gdsw_pkg::YEAR_W-1:0]         next_year,
    output logic [gdsw_pkg::MONTH_W-1:0]        next_month,
    output logic [gdsw_pkg::DAY_W-1:0]          next_dom,
    output logic [gdsw_pkg::WDAY_W-1:0]         weekday,
    output logic [gdsw_pkg::YEAR_W-1:0]         monday_year,
    output logic [gdsw_pkg::MONTH_W-1:0]        monday_month,
    output logic [gdsw_pkg::DAY_W-1:0]          monday_dom,
    output logic                                year_overflow
);
    import gdsw_pkg::*;

    // stage valid bits
    logic busy_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg, done_reg;

    // stage 1: registered input word
    year_t  s1_year_reg;
    month_t s1_month_reg;
    day_t   s1_day_reg;

    // stage 2: divide-by-100 products
    year_t                s2_year_reg, s2_p_reg;
    month_t               s2_month_reg;
    day_t                 s2_day_reg;
    logic [PROD100_W-1:0] s2_prod_y_reg, s2_prod_p_reg;
    year_t                p_next;
    logic [PROD100_W-1:0] prod_y_next, prod_p_next;

    // stage 3: validity, day count, following day
    logic             s3_valid_reg, s3_ovf_reg;
    year_t            s3_year_reg, s3_ny_reg;
    month_t           s3_month_reg, s3_nm_reg;
    day_t             s3_day_reg, s3_dim_reg, s3_nd_reg;
    logic [CNT_W-1:0] s3_cnt_reg;
    logic [7:0]       q_y, q_p;
    logic [CNT_W-1:0] c100;
    logic             y_div100, leap;
    day_t             dim_next;
    logic             valid_next;
    logic [CNT_W-1:0] cnt_next;
    year_t            ny_next;
    month_t           nm_next;
    day_t             nd_next;
    logic             ovf_next;

    // stage 4: divide-by-7 product
    logic               s4_valid_reg, s4_ovf_reg;
    year_t              s4_year_reg, s4_ny_reg;
    month_t             s4_month_reg, s4_nm_reg;
    day_t               s4_day_reg, s4_dim_reg, s4_nd_reg;
    logic [CNT_W-1:0]   s4_cnt_reg;
    logic [PROD7_W-1:0] s4_prod7_reg;
    logic [PROD7_W-1:0] prod7_next;

    // stage 5: weekday, next Monday, output registers
    logic [12:0] q7;
    logic [15:0] rem7;
    wday_t       r7, wd_next;
    logic [3:0]  steps;
    logic [5:0]  msum;
    year_t       my_next;
    month_t      mm_next;
    day_t        md_next;
    logic        ovf_mon;

    logic   date_valid_reg, year_overflow_reg;
    year_t  next_year_reg, monday_year_reg;
    month_t next_month_reg, monday_month_reg;
    day_t   next_dom_reg, monday_dom_reg;
    wday_t  weekday_reg;

    // control: valid bits ride with the words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= 1'b0;
            v1_reg   <= start && !busy_reg;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    // stage 2 logic: y/100 and (y-1)/100 by reciprocal
    always_comb
    begin
        p_next      = s1_year_reg - 14'd1;
        prod_y_next = PROD100_W'(s1_year_reg) * PROD100_W'(DIV100_MUL);
        prod_p_next = PROD100_W'(p_next) * PROD100_W'(DIV100_MUL);
    end

    // stage 3 logic: leap year, validity, weekday count, following day
    always_comb
    begin
        q_y      = s2_prod_y_reg[DIV100_SH +: 8];
        q_p      = s2_prod_p_reg[DIV100_SH +: 8];
        c100     = CNT_W'(q_y) * CNT_W'(100);
        y_div100 = (CNT_W'(s2_year_reg) == c100);
        leap     = ((s2_year_reg[1:0] == 2'd0) && !y_div100)
                   || (y_div100 && (q_y[1:0] == 2'd0));
        dim_next = month_len(s2_month_reg, leap);
        valid_next = (s2_year_reg != 14'd0) && (s2_year_reg <= YEAR_MAX)
                     && (s2_month_reg != 4'd0) && (s2_month_reg <= MONTH_DEC)
                     && (s2_day_reg != 5'd0) && (s2_day_reg <= dim_next);

        // 365 is 1 mod 7, so the year term reduces to p + p/4 - p/100 + p/400
        cnt_next = CNT_W'(s2_p_reg) + CNT_W'(s2_p_reg[YEAR_W-1:2])
                   + CNT_W'(q_p[7:2]) + CNT_W'(days_before(s2_month_reg, leap))
                   + CNT_W'(s2_day_reg) - CNT_W'(q_p);

        ny_next  = s2_year_reg;
        nm_next  = s2_month_reg;
        nd_next  = s2_day_reg + 5'd1;
        ovf_next = 1'b0;
        if (s2_day_reg >= dim_next)
        begin
            nd_next = DOM_FIRST;
            if (s2_month_reg >= MONTH_DEC)
            begin
                nm_next  = MONTH_JAN;
                ny_next  = s2_year_reg + 14'd1;
                ovf_next = (s2_year_reg >= YEAR_MAX);
            end
            else
            begin
                nm_next = s2_month_reg + 4'd1;
            end
        end
    end

    // stage 4 logic: count / 7 by reciprocal
    assign prod7_next = PROD7_W'(s3_cnt_reg) * PROD7_W'(DIV7_MUL);

    // stage 5 logic: weekday and the Monday after it
    always_comb
    begin
        q7    = s4_prod7_reg[DIV7_SH +: 13];
        rem7  = 16'(s4_cnt_reg) - 16'(q7) * 16'd7;
        r7    = rem7[2:0];
        // day 1 of the count is a Monday
        wd_next = (r7 == 3'd0) ? WDAY_SUN : r7;
        steps   = 4'd8 - {1'b0, wd_next};
        msum    = 6'(s4_day_reg) + 6'(steps);

        my_next = s4_year_reg;
        mm_next = s4_month_reg;
        md_next = msum[DAY_W-1:0];
        ovf_mon = 1'b0;
        // at most seven days ahead, so one month rollover at most
        if (msum > 6'(s4_dim_reg))
        begin
            md_next = 5'(msum - 6'(s4_dim_reg));
            if (s4_month_reg >= MONTH_DEC)
            begin
                mm_next = MONTH_JAN;
                my_next = s4_year_reg + 14'd1;
                ovf_mon = (s4_year_reg >= YEAR_MAX);
            end
            else
            begin
                mm_next = s4_month_reg + 4'd1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        s1_year_reg   <= in_year;
        s1_month_reg  <= in_month;
        s1_day_reg    <= in_day;

        s2_year_reg   <= s1_year_reg;
        s2_month_reg  <= s1_month_reg;
        s2_day_reg    <= s1_day_reg;
        s2_p_reg      <= p_next;
        s2_prod_y_reg <= prod_y_next;
        s2_prod_p_reg <= prod_p_next;

        s3_valid_reg  <= valid_next;
        s3_year_reg   <= s2_year_reg;
        s3_month_reg  <= s2_month_reg;
        s3_day_reg    <= s2_day_reg;
        s3_dim_reg    <= dim_next;
        s3_cnt_reg    <= cnt_next;
        s3_ny_reg     <= ny_next;
        s3_nm_reg     <= nm_next;
        s3_nd_reg     <= nd_next;
        s3_ovf_reg    <= ovf_next;

        s4_valid_reg  <= s3_valid_reg;
        s4_year_reg   <= s3_year_reg;
        s4_month_reg  <= s3_month_reg;
        s4_day_reg    <= s3_day_reg;
        s4_dim_reg    <= s3_dim_reg;
        s4_cnt_reg    <= s3_cnt_reg;
        s4_ny_reg     <= s3_ny_reg;
        s4_nm_reg     <= s3_nm_reg;
        s4_nd_reg     <= s3_nd_reg;
        s4_ovf_reg    <= s3_ovf_reg;
        s4_prod7_reg  <= prod7_next;

        // output word, zeroed for an invalid date; the following day or Monday is zeroed past the year limit
        date_valid_reg    <= s4_valid_reg;
        year_overflow_reg <= s4_valid_reg && (s4_ovf_reg || ovf_mon);
        weekday_reg       <= s4_valid_reg ? wd_next : 3'd0;
        if (s4_valid_reg && !s4_ovf_reg)
        begin
            next_year_reg  <= s4_ny_reg;
            next_month_reg <= s4_nm_reg;
            next_dom_reg   <= s4_nd_reg;
        end
        else
        begin
            next_year_reg  <= 14'd0;
            next_month_reg <= 4'd0;
            next_dom_reg   <= 5'd0;
        end
        if (s4_valid_reg && !ovf_mon)
        begin
            monday_year_reg  <= my_next;
            monday_month_reg <= mm_next;
            monday_dom_reg   <= md_next;
        end
        else
        begin
            monday_year_reg  <= 14'd0;
            monday_month_reg <= 4'd0;
            monday_dom_reg   <= 5'd0;
        end
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign date_valid    = date_valid_reg;
    assign next_year     = next_year_reg;
    assign next_month    = next_month_reg;
    assign next_dom      = next_dom_reg;
    assign weekday       = weekday_reg;
    assign monday_year   = monday_year_reg;
    assign monday_month  = monday_month_reg;
    assign monday_dom    = monday_dom_reg;
    assign year_overflow = year_overflow_reg;

    // checks
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 5))
        else $error("result strobe without a matching start");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !date_valid) |-> (weekday == 3'd0) && !year_overflow
                                  && (next_year == 14'd0) && (monday_year == 14'd0))
        else $error("invalid date with nonzero result fields");

    a_valid_weekday: assert property (@(posedge clk) disable iff (!rst_n)
        (done && date_valid) |-> (weekday != 3'd0) && (monday_dom != 5'd0 || year_overflow))
        else $error("valid date with no weekday or no Monday");

    a_next_present: assert property (@(posedge clk) disable iff (!rst_n)
        (done && date_valid && !year_overflow) |-> (next_year != 14'd0)
                                                   && (next_dom != 5'd0))
        else $error("following day missing without overflow");

endmodule

// File: bench/testbench.sv
// Self-checking bench for gregorian_date_step_and_weekday_core: one date word per
// handshake, each result checked against a calendar predictor kept in a small class.
// Depends on gdsw_pkg and the core RTL.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import gdsw_pkg::*;

    // Reference Monday used for the weekday count
    localparam int unsigned ANCHOR_YEAR  = 2013;
    localparam int unsigned ANCHOR_MONTH = 4;
    localparam int unsigned ANCHOR_DAY   = 8;
    localparam int unsigned LAST_YEAR    = 9999;
    localparam int unsigned DRAIN_LIMIT  = 200;

    // One result word
    typedef struct {
        logic   valid;
        year_t  nxt_year;
        month_t nxt_month;
        day_t   nxt_dom;
        wday_t  wday;
        year_t  mon_year;
        month_t mon_month;
        day_t   mon_dom;
        logic   ovf;
    } cal_word_t;

    class calendar_scoreboard;
        cal_word_t   expected_q[$];
        int unsigned mismatches;
        int unsigned n_dates;
        int unsigned n_valid;
        int unsigned n_ovf;
        int unsigned n_checked;

        function new();
            mismatches = 0;
            n_dates    = 0;
            n_valid    = 0;
            n_ovf      = 0;
            n_checked  = 0;
        endfunction

        function bit leap_year(input int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int unsigned month_days(input int unsigned y, input int unsigned m);
            int unsigned len;
            case (m)
                1, 3, 5, 7, 8, 10, 12: len = 31;
                4, 6, 9, 11:           len = 30;
                2:                     len = leap_year(y) ? 29 : 28;
                default:               len = 0;
            endcase
            return len;
        endfunction

        // Day serial with 0001-01-01 as day 1
        function int unsigned day_serial(input int unsigned y, input int unsigned m,
                                         input int unsigned d);
            int unsigned p;
            int unsigned n;
            p = y - 1;
            n = 365 * p + p / 4 - p / 100 + p / 400;
            for (int unsigned k = 1; k < m; k++)
                n += month_days(y, k);
            return n + d;
        endfunction

        // One day forward; returns 1 when the year runs past the last one
        function bit bump_day(inout int unsigned y, inout int unsigned m,
                              inout int unsigned d);
            if (d < month_days(y, m))
            begin
                d++;
                return 1'b0;
            end
            d = 1;
            if (m < 12)
            begin
                m++;
                return 1'b0;
            end
            m = 1;
            y++;
            return y > LAST_YEAR;
        endfunction

        function cal_word_t predict_calendar(input int unsigned y, input int unsigned m,
                                             input int unsigned d);
            cal_word_t   r;
            int unsigned ny;
            int unsigned nm;
            int unsigned nd;
            int unsigned wd;
            int unsigned anchor;
            bit          ovf_next;
            bit          ovf_mon;
            r.valid     = 1'b0;
            r.nxt_year  = '0;
            r.nxt_month = '0;
            r.nxt_dom   = '0;
            r.wday      = '0;
            r.mon_year  = '0;
            r.mon_month = '0;
            r.mon_dom   = '0;
            r.ovf       = 1'b0;
            if (y < 1 || y > LAST_YEAR || m < 1 || m > 12 || d < 1 || d > month_days(y, m))
                return r;
            r.valid = 1'b1;

            // following day
            ny = y; nm = m; nd = d;
            ovf_next = bump_day(ny, nm, nd);
            if (!ovf_next)
            begin
                r.nxt_year  = year_t'(ny);
                r.nxt_month = month_t'(nm);
                r.nxt_dom   = day_t'(nd);
            end

            // weekday relative to the anchor Monday
            anchor = day_serial(ANCHOR_YEAR, ANCHOR_MONTH, ANCHOR_DAY);
            wd = (day_serial(y, m, d) % 7 + 7 - anchor % 7) % 7 + 1;
            r.wday = wday_t'(wd);

            // next Monday strictly after the date
            ny = y; nm = m; nd = d;
            ovf_mon = 1'b0;
            for (int unsigned k = 0; k < 8 - wd && !ovf_mon; k++)
                ovf_mon = bump_day(ny, nm, nd);
            if (!ovf_mon)
            begin
                r.mon_year  = year_t'(ny);
                r.mon_month = month_t'(nm);
                r.mon_dom   = day_t'(nd);
            end
            r.ovf = ovf_next || ovf_mon;
            return r;
        endfunction

        function void note_date(input int unsigned y, input int unsigned m,
                                input int unsigned d);
            cal_word_t r;
            r = predict_calendar(y, m, d);
            n_dates++;
            if (r.valid)
                n_valid++;
            if (r.ovf)
                n_ovf++;
            expected_q.push_back(r);
        endfunction

        function string show(input cal_word_t r);
            return $sformatf("v=%0d next=%0d-%0d-%0d wd=%0d mon=%0d-%0d-%0d ovf=%0d",
                             r.valid, r.nxt_year, r.nxt_month, r.nxt_dom, r.wday,
                             r.mon_year, r.mon_month, r.mon_dom, r.ovf);
        endfunction

        function void check_result(input cal_word_t got);
            cal_word_t want;
            bit        bad;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word with no date pending: %s", $realtime, show(got));
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            bad = (got.valid !== want.valid) || (got.nxt_year !== want.nxt_year) ||
                  (got.nxt_month !== want.nxt_month) || (got.nxt_dom !== want.nxt_dom) ||
                  (got.wday !== want.wday) || (got.mon_year !== want.mon_year) ||
                  (got.mon_month !== want.mon_month) || (got.mon_dom !== want.mon_dom) ||
                  (got.ovf !== want.ovf);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: mismatch", $realtime);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    year_t  in_year = '0;
    month_t in_month = '0;
    day_t   in_day = '0;
    logic   done;
    logic   date_valid;
    year_t  next_year;
    month_t next_month;
    day_t   next_dom;
    wday_t  weekday;
    year_t  monday_year;
    month_t monday_month;
    day_t   monday_dom;
    logic   year_overflow;

    calendar_scoreboard sb = new();

    gregorian_date_step_and_weekday_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .in_year       (in_year),
        .in_month      (in_month),
        .in_day        (in_day),
        .done          (done),
        .date_valid    (date_valid),
        .next_year     (next_year),
        .next_month    (next_month),
        .next_dom      (next_dom),
        .weekday       (weekday),
        .monday_year   (monday_year),
        .monday_month  (monday_month),
        .monday_dom    (monday_dom),
        .year_overflow (year_overflow)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Monitor: note accepted words, check strobed results
    always @(posedge clk)
    begin
        cal_word_t got;
        if (start && !busy)
            sb.note_date(in_year, in_month, in_day);
        if (rst_n && done)
        begin
            got.valid     = date_valid;
            got.nxt_year  = next_year;
            got.nxt_month = next_month;
            got.nxt_dom   = next_dom;
            got.wday      = weekday;
            got.mon_year  = monday_year;
            got.mon_month = monday_month;
            got.mon_dom   = monday_dom;
            got.ovf       = year_overflow;
            sb.check_result(got);
        end
    end

    // Drive one date word and hold it until the core takes it
    task automatic send_date(input int unsigned y, input int unsigned m, input int unsigned d);
        start    <= 1'b1;
        in_year  <= year_t'(y);
        in_month <= month_t'(m);
        in_day   <= day_t'(d);
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Random sender idle: each cycle idles with 29 percent chance
    task automatic maybe_idle(input bit allow);
        while (allow && ($urandom_range(0, 99) < 29))
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Hold off the sender until every pending result has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic int unsigned pick_year();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return $urandom_range(1, 12);
            1:       return $urandom_range(LAST_YEAR - 9, LAST_YEAR);
            2:       return 100 * $urandom_range(1, 99);
            3:       return 4 * $urandom_range(1, 2499);
            default: return $urandom_range(1, LAST_YEAR);
        endcase
    endfunction

    // Mostly well-formed dates, weighted toward month ends; rest broken or raw noise
    task automatic make_date(output int unsigned y, output int unsigned m,
                             output int unsigned d);
        int unsigned sel;
        int unsigned len;
        sel = $urandom_range(0, 99);
        y = pick_year();
        m = $urandom_range(1, 12);
        len = sb.month_days(y, m);
        if (sel < 45)
            d = $urandom_range(1, len);
        else if (sel < 75)
            d = $urandom_range(len - 6, len);
        else if (sel < 85)
            d = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(len + 1, 31);
        else
        begin
            y = $urandom_range(0, 16383);
            m = $urandom_range(0, 15);
            d = $urandom_range(0, 31);
        end
    endtask

    initial
    begin
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned waited;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        // corner dates
        send_date(0, 0, 0);             maybe_idle(1'b1);
        send_date(1, 1, 1);             maybe_idle(1'b1);
        send_date(16383, 15, 31);       maybe_idle(1'b1);
        send_date(10000, 1, 1);         maybe_idle(1'b1);
        send_date(9999, 12, 31);        maybe_idle(1'b1);
        send_date(9999, 12, 28);        maybe_idle(1'b1);
        send_date(9999, 12, 26);        maybe_idle(1'b1);
        send_date(9999, 1, 1);          maybe_idle(1'b1);
        send_date(2000, 2, 29);         maybe_idle(1'b1);
        send_date(400, 2, 29);          maybe_idle(1'b1);
        send_date(1900, 2, 29);         maybe_idle(1'b1);
        send_date(2100, 2, 28);         maybe_idle(1'b1);
        send_date(2024, 2, 29);         maybe_idle(1'b1);
        send_date(2023, 2, 29);         maybe_idle(1'b1);
        send_date(2023, 2, 28);         maybe_idle(1'b1);
        send_date(ANCHOR_YEAR, ANCHOR_MONTH, ANCHOR_DAY);
        maybe_idle(1'b1);
        send_date(2013, 4, 7);          maybe_idle(1'b1);
        send_date(2023, 12, 31);        maybe_idle(1'b1);
        send_date(2023, 4, 30);         maybe_idle(1'b1);
        send_date(2023, 4, 31);         maybe_idle(1'b1);
        send_date(2023, 13, 1);         maybe_idle(1'b1);
        send_date(2023, 1, 0);          maybe_idle(1'b1);
        send_date(2023, 1, 31);         maybe_idle(1'b1);
        send_date(2023, 6, 15);
        drain_results();

        // random dates; one back-to-back stretch and one full drain midway
        for (int i = 0; i < 650; i++)
        begin
            make_date(y, m, d);
            send_date(y, m, d);
            if (i == 400)
                drain_results();
            else
                maybe_idle(!(i >= 250 && i < 370));
        end
        start <= 1'b0;
        @(posedge clk);

        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.pending() != 0)
        begin
            $display("testbench: errors");
            $finish;
        end
        else
        begin
            repeat (10)
                @(posedge clk);
            $display("Covered %0d dates (%0d valid, %0d invalid), %0d with year overflow;",
                     sb.n_dates, sb.n_valid, sb.n_dates - sb.n_valid, sb.n_ovf);
            $display("%0d results compared, %0d mismatches.", sb.n_checked, sb.mismatches);
            if (sb.mismatches == 0 && sb.pending() == 0)
                $display("testbench: clean");
            else
                $display("testbench: errors");
            $finish;
        end
    end

    // Hard stop in case the core hangs
    initial
    begin
        #2000000;
        $display("testbench: errors");
        $finish;
    end

endmodule

// File: gregorian_date_step_and_weekday_core.f
design/gdsw_pkg.sv
design/gregorian_date_step_and_weekday_core.sv
bench/testbench.sv
